### src/matrix_multiply_4x4_defines.svh
// Assertion macros shared by the matrix multiplier RTL.
// Expects clk and rst in the scope of every use.
`ifndef MATRIX_MULTIPLY_4X4_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mm4x4_pkg.sv
// Shared constants and types of the matrix multiplier.
// No dependencies; every file but the macro header imports it.
package mm4x4_pkg;

  localparam int DIM_DEFAULT = 4;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int POS_W       = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input channel may accept a word
    logic rd_en;     // issue one store read pair
    logic rd_first;  // first term of a dot product
    logic rd_last;   // last term of a dot product
    logic load_out;  // load the result register
    logic out_last;  // element being loaded is the final one
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_fire;  // accepted word asks for a product
    logic acc_done;    // accumulator holds a finished dot product
    logic out_free;    // result register can take a new element
  } status_t;

endpackage

### src/mm4x4_in_if.sv
// Input channel: one element pair of A and B plus the start flag.
// Depends on mm4x4_pkg.
interface mm4x4_in_if;
  import mm4x4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         row_index;
  logic [POS_W-1:0]         col_index;
  logic signed [DATA_W-1:0] a_value;
  logic signed [DATA_W-1:0] b_value;
  logic                     start_req;

  modport source (output valid, row_index, col_index, a_value, b_value, start_req,
                  input ready);
  modport sink (input valid, row_index, col_index, a_value, b_value, start_req,
                output ready);
endinterface

### src/mm4x4_out_if.sv
// Output channel: one element of the product matrix.
// Depends on mm4x4_pkg.
interface mm4x4_out_if;
  import mm4x4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

### src/mm4x4_dp.sv
// Datapath: element stores, multiply-accumulate pipe, saturation, result register.
// Depends on mm4x4_pkg, the channel interfaces and the assertion macros.
`include "matrix_multiply_4x4_defines.svh"

module mm4x4_dp #(
  parameter int DIM = mm4x4_pkg::DIM_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  mm4x4_in_if.sink                  in_ch,
  mm4x4_out_if.source               out_ch,
  input  mm4x4_pkg::cmd_t           cmd,
  output mm4x4_pkg::status_t        status,
  input  logic [$clog2(DIM)-1:0]    rd_row,
  input  logic [$clog2(DIM)-1:0]    rd_col,
  input  logic [$clog2(DIM)-1:0]    rd_k
);
  import mm4x4_pkg::*;

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int SH_W   = ACC_W - FRAC_W;
  localparam logic signed [SH_W-1:0] SAT_HI = {{(SH_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO = {{(SH_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] left_mem  [CELLS];
  logic [DATA_W-1:0] right_mem [CELLS];

  logic              in_fire;
  logic              in_range;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;

  logic                     rd_vld, rd_first, rd_last;
  logic signed [DATA_W-1:0] a_q, b_q;
  logic                     prod_vld, prod_first, prod_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;
  logic signed [SH_W-1:0]   shifted;
  logic [DATA_W-1:0]        sat_value;

  logic                     res_vld;
  logic [POS_W-1:0]         res_row, res_col;
  logic [DATA_W-1:0]        res_value;
  logic                     res_last;

  // Input side
  assign in_ch.ready = cmd.take;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_range    = (32'(in_ch.row_index) < DIM) && (32'(in_ch.col_index) < DIM);
  assign wr_en       = in_fire & in_range;
  assign wr_addr     = ADDR_W'(32'(in_ch.row_index) * DIM + 32'(in_ch.col_index));

  assign a_raddr = ADDR_W'(32'(rd_row) * DIM + 32'(rd_k));
  assign b_raddr = ADDR_W'(32'(rd_k) * DIM + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= in_ch.a_value;
      right_mem[wr_addr] <= in_ch.b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_q <= left_mem[a_raddr];
      b_q <= right_mem[b_raddr];
    end
  end

  // Pipe control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_vld   <= cmd.rd_en;
      prod_vld <= rd_vld;
      acc_done <= prod_vld & prod_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_first   <= cmd.rd_first;
    rd_last    <= cmd.rd_last;
    prod_first <= rd_first;
    prod_last  <= rd_last;
    if (rd_vld) begin
      prod <= a_q * b_q;
    end
    if (prod_vld) begin
      acc <= prod_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Floor shift to Q16.16, then clamp to 32 bits.
  assign shifted = SH_W'(acc >>> FRAC_W);

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[DATA_W-1:0];
    end else begin
      sat_value = shifted[DATA_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (cmd.load_out) begin
      res_vld <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_row   <= POS_W'(rd_row);
      res_col   <= POS_W'(rd_col);
      res_value <= sat_value;
      res_last  <= cmd.out_last;
    end
  end

  assign out_ch.valid     = res_vld;
  assign out_ch.out_row   = res_row;
  assign out_ch.out_col   = res_col;
  assign out_ch.out_value = res_value;
  assign out_ch.last      = res_last;

  assign status.start_fire = in_fire & in_ch.start_req;
  assign status.acc_done   = acc_done;
  assign status.out_free   = ~res_vld | out_ch.ready;

  `MM_ASSERT_NOW(a_no_overwrite, cmd.load_out, !res_vld || out_ch.ready, "result overwritten while pending")
  `MM_ASSERT_NOW(a_drained_on_done, acc_done, !rd_vld && !prod_vld, "dot product done with terms in flight")
  `MM_ASSERT_NOW(a_idle_on_write, in_fire, !rd_vld && !prod_vld && !cmd.rd_en, "store written during a product")
endmodule

### src/mm4x4_ctrl.sv
// Controller: sequences rows, columns and terms of the product.
// Depends on mm4x4_pkg and the assertion macros.
`include "matrix_multiply_4x4_defines.svh"

module mm4x4_ctrl #(
  parameter int DIM = mm4x4_pkg::DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  output mm4x4_pkg::cmd_t        cmd,
  input  mm4x4_pkg::status_t     status,
  output logic [$clog2(DIM)-1:0] rd_row,
  output logic [$clog2(DIM)-1:0] rd_col,
  output logic [$clog2(DIM)-1:0] rd_k
);
  import mm4x4_pkg::*;

  localparam int IDX_W = $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] r, r_next;
  logic [IDX_W-1:0] c, c_next;
  logic [IDX_W-1:0] k, k_next;
  logic             at_end;

  assign at_end = (r == IDX_MAX) && (c == IDX_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (status.start_fire) state_next = ST_RUN;
      ST_RUN:  if (k == IDX_MAX) state_next = ST_WAIT;
      ST_WAIT: if (status.acc_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) state_next = at_end ? ST_IDLE : ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Counters: advance the term in RUN, the element after each emit.
  always_comb begin
    r_next = r;
    c_next = c;
    k_next = k;
    unique case (state)
      ST_IDLE: begin
        r_next = '0;
        c_next = '0;
        k_next = '0;
      end
      ST_RUN: k_next = (k == IDX_MAX) ? '0 : k + 1'b1;
      ST_WAIT: k_next = '0;
      ST_EMIT: begin
        if (status.out_free) begin
          if (c == IDX_MAX) begin
            c_next = '0;
            r_next = (r == IDX_MAX) ? '0 : r + 1'b1;
          end else begin
            c_next = c + 1'b1;
          end
        end
      end
      default: k_next = '0;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.take = 1'b1;
      ST_RUN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k == '0);
        cmd.rd_last  = (k == IDX_MAX);
      end
      ST_WAIT: cmd = '0;
      ST_EMIT: begin
        cmd.load_out = status.out_free;
        cmd.out_last = at_end;
      end
      default: cmd = '0;
    endcase
  end

  assign rd_row = r;
  assign rd_col = c;
  assign rd_k   = k;

  `MM_ASSERT_NOW(a_start_when_idle, status.start_fire, state == ST_IDLE, "start taken while busy")
  `MM_ASSERT_NEXT(a_final_to_idle, cmd.load_out && cmd.out_last, state == ST_IDLE, "missed return to idle")
endmodule

### src/matrix_multiply_4x4.sv
// Top level of the DIM x DIM signed Q16.16 matrix multiplier.
// Depends on mm4x4_pkg, the channel interfaces, mm4x4_ctrl and mm4x4_dp.
//
// Usage:
//   in_ch carries one word per element pair: row_index, col_index, a_value
//   (element of A) and b_value (element of B at the same place). An index at
//   or beyond DIM is not stored. start_req = 1 stores the pair, then starts
//   C = A * B over the stored elements.
//   out_ch returns DIM*DIM words in row-major order, out_value saturated to
//   32 bits, last set on the final word.
// Sequencing:
//   A word without start only stores its pair, and in_ch stays ready. After
//   a start word each element passes through the single shared
//   multiply-accumulate (read the two stores, multiply, accumulate,
//   saturate) before the next element begins. in_ch.ready stays low while
//   the product runs and rises again once the last element is registered.
// Reset: rst (synchronous, active high) idles the sequencer and empties the
//   pipe and the result register. The stores are not cleared: every element
//   must be written before the first start.
// Stall: a low out_ch.ready holds the result register and the sequencer
//   waits for it; no element is lost or repeated.
module matrix_multiply_4x4 #(
  parameter int DIM = mm4x4_pkg::DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  mm4x4_in_if.sink    in_ch,
  mm4x4_out_if.source out_ch
);
  import mm4x4_pkg::*;

  localparam int IDX_W = $clog2(DIM);

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_row;
  logic [IDX_W-1:0] rd_col;
  logic [IDX_W-1:0] rd_k;

  // Sequencer: walks elements and terms, gates both channels.
  mm4x4_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .rd_row (rd_row),
    .rd_col (rd_col),
    .rd_k   (rd_k)
  );

  // Stores, multiply-accumulate pipe and the result register.
  mm4x4_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status),
    .rd_row (rd_row),
    .rd_col (rd_col),
    .rd_k   (rd_k)
  );
endmodule
